// File: design/rst_pkg.sv
// ----------------------------------------------------------------------------
// Randomized set table package
// Shared types, codes and constants for the set table controller and datapath.
// ----------------------------------------------------------------------------
package rst_pkg;

   localparam int ACTION_W    = 2;
   localparam int VALUE_W     = 12;
   localparam int COUNT_OUT_W = 11;
   localparam int LFSR_W      = 32;

   localparam logic [LFSR_W-1:0] LFSR_TAPS = 32'hD000_0001;

   localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_PICK   = 2'd2;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_DECIDE,
      ST_RM_MOVE,
      ST_RM_DROP,
      ST_MOD,
      ST_PICK_TAKE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic clear_step;
      logic latch_req;
      logic st_read;
      logic ins_commit;
      logic ms_read_last;
      logic rm_move;
      logic rm_drop;
      logic pick_start;
      logic ms_read_pick;
      logic take_pick;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic                in_space;
      logic                entry_valid;
      logic                full;
      logic                empty;
      logic                mod_done;
      logic                clr_last;
      logic                rsp_free;
   } status_type;

   // Galois LFSR step, shifting right.
   function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] s);
      logic [LFSR_W-1:0] shifted;
      shifted = {1'b0, s[LFSR_W-1:1]};
      return s[0] ? (shifted ^ LFSR_TAPS) : shifted;
   endfunction

endpackage

// File: design/rst_mod.sv
// ----------------------------------------------------------------------------
// Remainder unit
// Bit-serial restoring reduction of a 32-bit word modulo the member count,
// one dividend bit per cycle.
// ----------------------------------------------------------------------------
module rst_mod #(
   parameter int CW = 11,
   parameter int SW = 10
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [rst_pkg::LFSR_W-1:0]  dividend,
   input  logic [CW-1:0]               divisor,
   output logic                        done,
   output logic [SW-1:0]               remainder
);

   localparam int STEP_W = $clog2(rst_pkg::LFSR_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(rst_pkg::LFSR_W - 1);

   logic                       busy_ff;
   logic                       done_ff;
   logic [STEP_W-1:0]          step_ff;
   logic [rst_pkg::LFSR_W-1:0] quo_ff;
   logic [CW-1:0]              rem_ff;
   logic [CW-1:0]              div_ff;
   logic [CW:0]                shifted;
   logic [CW-1:0]              rem_in;

   // The partial remainder always stays below the divisor, so it fits CW bits.
   assign shifted = {rem_ff, quo_ff[rst_pkg::LFSR_W-1]};
   assign rem_in  = (shifted >= {1'b0, div_ff}) ? CW'(shifted - {1'b0, div_ff})
                                                : CW'(shifted);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[rst_pkg::LFSR_W-2:0], 1'b0};
         rem_ff <= rem_in;
      end
   end

   assign done      = done_ff;
   assign remainder = SW'(rem_ff);

endmodule

// File: design/rst_dp.sv
// ----------------------------------------------------------------------------
// Set table datapath
// Index table, member store, count, LFSR, request latch and result register.
// ----------------------------------------------------------------------------
module rst_dp #(
   parameter int KEY_SPACE = 4096,
   parameter int CAPACITY  = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  rst_pkg::cmd_type                    cmd,
   output rst_pkg::status_type                 status,
   input  logic [rst_pkg::ACTION_W-1:0]        req_action,
   input  logic signed [rst_pkg::VALUE_W-1:0]  req_value,
   input  logic                                csr_write,
   input  logic [rst_pkg::LFSR_W-1:0]          csr_seed,
   input  logic                                rsp_tready,
   output logic                                rsp_valid,
   output logic                                rsp_ok,
   output logic signed [rst_pkg::VALUE_W-1:0]  rsp_picked,
   output logic [rst_pkg::COUNT_OUT_W-1:0]     rsp_count
);

   localparam int KW      = $clog2(KEY_SPACE);
   localparam int SW      = $clog2(CAPACITY);
   localparam int CW      = $clog2(CAPACITY + 1);
   localparam int SUM_W   = ((KW > rst_pkg::VALUE_W) ? KW : rst_pkg::VALUE_W) + 2;
   localparam int ENTRY_W = SW + 1;
   localparam logic signed [SUM_W-1:0] HALF_KEYS = SUM_W'(KEY_SPACE / 2);
   localparam logic signed [SUM_W-1:0] KEY_LIMIT = SUM_W'(KEY_SPACE);

   logic [ENTRY_W-1:0]                 st_mem [KEY_SPACE];
   logic [rst_pkg::VALUE_W-1:0]        ms_mem [CAPACITY];

   logic [rst_pkg::ACTION_W-1:0]       action_ff;
   logic signed [rst_pkg::VALUE_W-1:0] value_ff;
   logic [KW-1:0]                      clr_ff;
   logic [CW-1:0]                      count_ff;
   logic [CW-1:0]                      count_in;
   logic [rst_pkg::LFSR_W-1:0]         lfsr_ff;
   logic [rst_pkg::LFSR_W-1:0]         lfsr_step;
   logic                               ok_ff;
   logic signed [rst_pkg::VALUE_W-1:0] picked_ff;
   logic [ENTRY_W-1:0]                 st_rd_ff;
   logic signed [rst_pkg::VALUE_W-1:0] ms_rd_ff;
   logic                               rsp_valid_ff;
   logic                               rsp_ok_ff;
   logic signed [rst_pkg::VALUE_W-1:0] rsp_picked_ff;
   logic [rst_pkg::COUNT_OUT_W-1:0]    rsp_count_ff;

   logic signed [SUM_W-1:0]            sum_req;
   logic signed [SUM_W-1:0]            sum_last;
   logic                               req_in_space;
   logic                               last_in_space;
   logic [KW-1:0]                      key_req;
   logic [KW-1:0]                      key_last;
   logic [SW-1:0]                      slot_idx;
   logic [SW-1:0]                      last_slot;
   logic [SW-1:0]                      mod_rem;
   logic                               mod_done;

   logic                               st_we;
   logic [KW-1:0]                      st_waddr;
   logic [ENTRY_W-1:0]                 st_wdata;
   logic                               ms_we;
   logic [SW-1:0]                      ms_waddr;
   logic [rst_pkg::VALUE_W-1:0]        ms_wdata;
   logic                               ms_re;
   logic [SW-1:0]                      ms_raddr;

   // Table address is the value offset by half the key space.
   assign sum_req       = SUM_W'(value_ff) + HALF_KEYS;
   assign sum_last      = SUM_W'(ms_rd_ff) + HALF_KEYS;
   assign req_in_space  = !sum_req[SUM_W-1] && (sum_req < KEY_LIMIT);
   assign last_in_space = !sum_last[SUM_W-1] && (sum_last < KEY_LIMIT);
   assign key_req       = sum_req[KW-1:0];
   assign key_last      = sum_last[KW-1:0];
   assign slot_idx      = st_rd_ff[SW-1:0];
   assign last_slot     = SW'(count_ff - 1'b1);
   assign lfsr_step     = rst_pkg::lfsr_next(lfsr_ff);

   rst_mod #(
      .CW (CW),
      .SW (SW)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.pick_start),
      .dividend  (lfsr_step),
      .divisor   (count_ff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // Index table write port.
   always_comb begin
      st_we    = 1'b0;
      st_waddr = key_req;
      st_wdata = '0;
      if (cmd.clear_step) begin
         st_we    = 1'b1;
         st_waddr = clr_ff;
      end else if (cmd.ins_commit) begin
         st_we    = 1'b1;
         st_wdata = {1'b1, SW'(count_ff)};
      end else if (cmd.rm_move) begin
         st_we    = last_in_space;
         st_waddr = key_last;
         st_wdata = {1'b1, slot_idx};
      end else if (cmd.rm_drop) begin
         st_we    = 1'b1;
      end
   end

   // Member store ports.
   always_comb begin
      ms_we    = 1'b0;
      ms_waddr = SW'(count_ff);
      ms_wdata = value_ff;
      if (cmd.ins_commit) begin
         ms_we = 1'b1;
      end else if (cmd.rm_move) begin
         ms_we    = 1'b1;
         ms_waddr = slot_idx;
         ms_wdata = ms_rd_ff;
      end
      ms_re    = cmd.ms_read_last || cmd.ms_read_pick;
      ms_raddr = cmd.ms_read_last ? last_slot : mod_rem;
   end

   always_ff @(posedge clock) begin
      if (st_we) begin
         st_mem[st_waddr] <= st_wdata;
      end
      if (cmd.st_read) begin
         st_rd_ff <= st_mem[key_req];
      end
   end

   always_ff @(posedge clock) begin
      if (ms_we) begin
         ms_mem[ms_waddr] <= ms_wdata;
      end
      if (ms_re) begin
         ms_rd_ff <= ms_mem[ms_raddr];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.ins_commit) begin
         count_in = CW'(count_ff + 1'b1);
      end else if (cmd.rm_drop) begin
         count_in = CW'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         count_ff     <= '0;
         lfsr_ff      <= rst_pkg::LFSR_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (cmd.clear_step) begin
            clr_ff <= clr_ff + 1'b1;
         end
         // A zero seed would lock the generator, so it is replaced by one.
         if (csr_write) begin
            lfsr_ff <= (csr_seed == '0) ? rst_pkg::LFSR_W'(1) : csr_seed;
         end else if (cmd.pick_start) begin
            lfsr_ff <= lfsr_step;
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         action_ff <= req_action;
         value_ff  <= req_value;
         ok_ff     <= 1'b0;
         picked_ff <= '0;
      end else begin
         if (cmd.ins_commit || cmd.rm_drop || cmd.take_pick) begin
            ok_ff <= 1'b1;
         end
         if (cmd.take_pick) begin
            picked_ff <= ms_rd_ff;
         end
      end
      if (cmd.load_rsp) begin
         rsp_ok_ff     <= ok_ff;
         rsp_picked_ff <= picked_ff;
         rsp_count_ff  <= rst_pkg::COUNT_OUT_W'(count_ff);
      end
   end

   always_comb begin
      status.action      = action_ff;
      status.in_space    = req_in_space;
      status.entry_valid = st_rd_ff[SW];
      status.full        = (count_ff == CW'(CAPACITY));
      status.empty       = (count_ff == '0);
      status.mod_done    = mod_done;
      status.clr_last    = (clr_ff == KW'(KEY_SPACE - 1));
      status.rsp_free    = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_ok     = rsp_ok_ff;
   assign rsp_picked = rsp_picked_ff;
   assign rsp_count  = rsp_count_ff;

endmodule

// File: design/rst_ctrl.sv
// ----------------------------------------------------------------------------
// Set table controller
// Sequences the clearing pass and each insert, remove and pick operation.
// ----------------------------------------------------------------------------
module rst_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  rst_pkg::status_type status,
   output rst_pkg::cmd_type    cmd
);

   rst_pkg::state_type state_ff;
   rst_pkg::state_type state_in;
   logic               ins_ok;
   logic               rm_ok;
   logic               pick_ok;

   assign ins_ok  = (status.action == rst_pkg::ACT_INSERT) && status.in_space
                    && !status.entry_valid && !status.full;
   assign rm_ok   = (status.action == rst_pkg::ACT_REMOVE) && status.in_space
                    && status.entry_valid && !status.empty;
   assign pick_ok = (status.action == rst_pkg::ACT_PICK) && !status.empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rst_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rst_pkg::ST_CLEAR: begin
            if (status.clr_last) state_in = rst_pkg::ST_IDLE;
         end
         rst_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = rst_pkg::ST_LOOKUP;
         end
         rst_pkg::ST_LOOKUP: begin
            state_in = rst_pkg::ST_DECIDE;
         end
         rst_pkg::ST_DECIDE: begin
            if (rm_ok) begin
               state_in = rst_pkg::ST_RM_MOVE;
            end else if (pick_ok) begin
               state_in = rst_pkg::ST_MOD;
            end else begin
               state_in = rst_pkg::ST_DONE;
            end
         end
         rst_pkg::ST_RM_MOVE: begin
            state_in = rst_pkg::ST_RM_DROP;
         end
         rst_pkg::ST_RM_DROP: begin
            state_in = rst_pkg::ST_DONE;
         end
         rst_pkg::ST_MOD: begin
            if (status.mod_done) state_in = rst_pkg::ST_PICK_TAKE;
         end
         rst_pkg::ST_PICK_TAKE: begin
            state_in = rst_pkg::ST_DONE;
         end
         rst_pkg::ST_DONE: begin
            if (status.rsp_free) state_in = rst_pkg::ST_IDLE;
         end
         default: begin
            state_in = rst_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         rst_pkg::ST_CLEAR: begin
            cmd.clear_step = 1'b1;
         end
         rst_pkg::ST_IDLE: begin
            req_tready    = 1'b1;
            cmd.latch_req = req_tvalid;
         end
         rst_pkg::ST_LOOKUP: begin
            cmd.st_read = 1'b1;
         end
         rst_pkg::ST_DECIDE: begin
            cmd.ins_commit   = ins_ok;
            cmd.ms_read_last = rm_ok;
            cmd.pick_start   = pick_ok;
         end
         rst_pkg::ST_RM_MOVE: begin
            cmd.rm_move = 1'b1;
         end
         rst_pkg::ST_RM_DROP: begin
            cmd.rm_drop = 1'b1;
         end
         rst_pkg::ST_MOD: begin
            cmd.ms_read_pick = status.mod_done;
         end
         rst_pkg::ST_PICK_TAKE: begin
            cmd.take_pick = 1'b1;
         end
         rst_pkg::ST_DONE: begin
            cmd.load_rsp = status.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// File: design/randomized_set_table.sv
// Each operation passes through the lookup and decide states before its result
// is loaded; a remove adds the move and drop states, and a successful pick waits
// for the bit-serial remainder unit, which sets the pick time. No new request is
// taken until the result of the last one is loaded. A stalled result holds the
// controller until it is taken.
// After reset the index table is cleared with req_tready low.
// ----------------------------------------------------------------------------
// Randomized set table
// Set of signed values with insert, remove and pseudo-random pick.
// ----------------------------------------------------------------------------
module randomized_set_table #(
   parameter int KEY_SPACE = 4096,
   parameter int CAPACITY  = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [11:0] value, [15:12] zero
   input  logic [1:0]  req_tuser,   // [1:0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [0] ok, [12:1] picked, [23:13] member_count
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data     // random_seed
);

   rst_pkg::cmd_type                   cmd;
   rst_pkg::status_type                status;
   logic                               rsp_ok;
   logic signed [rst_pkg::VALUE_W-1:0] rsp_picked;
   logic [rst_pkg::COUNT_OUT_W-1:0]    rsp_count;

   assign csr_ready = 1'b1;

   rst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   rst_dp #(
      .KEY_SPACE (KEY_SPACE),
      .CAPACITY  (CAPACITY)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_action (req_tuser),
      .req_value  (req_tdata[rst_pkg::VALUE_W-1:0]),
      .csr_write  (csr_valid),
      .csr_seed   (csr_data),
      .rsp_tready (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_ok     (rsp_ok),
      .rsp_picked (rsp_picked),
      .rsp_count  (rsp_count)
   );

   assign rsp_tdata = {rsp_count, rsp_picked, rsp_ok};

endmodule

// File: design/rst_check.sv
// ----------------------------------------------------------------------------
// Set table port checker
// Checks result ordering and field consistency seen on the top-level ports.
// ----------------------------------------------------------------------------
module rst_check #(
   parameter int CAPACITY = 1024
) (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   // A stalled result keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // Operations run one at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken while busy");

   // A rejected operation never reports a picked member.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[12:1] == 12'd0)
      else $error("picked value on rejected operation");

   // The member count never exceeds the store size.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> int'(rsp_tdata[23:13]) <= CAPACITY)
      else $error("member count above capacity");

endmodule

bind randomized_set_table rst_check #(
   .CAPACITY (CAPACITY)
) u_rst_check (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: sim/randomized_set_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Randomized set table checker
// Watches the request, result and seed channels, keeps its own copy of the
// set, the slot index and the pick generator, and compares every result
// transfer field by field with the oldest pending prediction.
// ----------------------------------------------------------------------------
module randomized_set_table_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [31:0] csr_data,
   output int          mismatches,
   output int          outstanding,
   output int          ops_seen,
   output int          picks_hit,
   output int          peak_members
);

   localparam int KEY_SPACE = 4096;
   localparam int KEY_HALF  = KEY_SPACE / 2;
   localparam int CAPACITY  = 1024;
   localparam logic [rst_pkg::LFSR_W-1:0] PICK_FEEDBACK = 32'hD000_0001;

   typedef struct packed {
      logic                            ok;
      logic [rst_pkg::VALUE_W-1:0]     picked;
      logic [rst_pkg::COUNT_OUT_W-1:0] members;
   } set_outcome_type;

   logic [rst_pkg::COUNT_OUT_W-1:0] slot_of_key [KEY_SPACE];
   bit                              key_used [KEY_SPACE];
   logic [rst_pkg::VALUE_W-1:0]     members_by_slot [CAPACITY];
   int unsigned                     live_count;
   logic [rst_pkg::LFSR_W-1:0]      pick_state;
   set_outcome_type                 outcome_q [$];
   set_outcome_type                 due;
   set_outcome_type                 fresh;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH at %0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
      mismatches++;
   endtask

   function automatic logic [rst_pkg::LFSR_W-1:0] advance_pick(
      input logic [rst_pkg::LFSR_W-1:0] s);
      return {1'b0, s[rst_pkg::LFSR_W-1:1]} ^ ({rst_pkg::LFSR_W{s[0]}} & PICK_FEEDBACK);
   endfunction

   // Applies one operation to the shadow set and returns the result it must give.
   function automatic set_outcome_type apply_set_op(
      input logic [rst_pkg::ACTION_W-1:0]       act,
      input logic signed [rst_pkg::VALUE_W-1:0] val);
      set_outcome_type res;
      int key;
      int idx;
      int unsigned last;
      logic signed [rst_pkg::VALUE_W-1:0] moved;
      res = '0;
      key = int'(val) + KEY_HALF;
      case (act)
         rst_pkg::ACT_INSERT: begin
            if (key >= 0 && key < KEY_SPACE && !key_used[key] && live_count < CAPACITY) begin
               members_by_slot[live_count] = val;
               slot_of_key[key] = live_count[rst_pkg::COUNT_OUT_W-1:0];
               key_used[key] = 1'b1;
               live_count++;
               res.ok = 1'b1;
            end
         end
         rst_pkg::ACT_REMOVE: begin
            if (key >= 0 && key < KEY_SPACE && key_used[key] && live_count > 0) begin
               idx  = int'(slot_of_key[key]);
               last = live_count - 1;
               if (idx < live_count) begin
                  // The last member fills the hole, and its index entry follows it.
                  moved = members_by_slot[last];
                  members_by_slot[idx] = moved;
                  slot_of_key[int'(moved) + KEY_HALF] = idx[rst_pkg::COUNT_OUT_W-1:0];
                  key_used[key] = 1'b0;
                  live_count = last;
                  res.ok = 1'b1;
               end
            end
         end
         rst_pkg::ACT_PICK: begin
            if (live_count > 0) begin
               pick_state = advance_pick(pick_state);
               res.picked = members_by_slot[pick_state % live_count];
               res.ok = 1'b1;
            end
         end
         default: ;
      endcase
      res.members = live_count[rst_pkg::COUNT_OUT_W-1:0];
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         foreach (key_used[i]) key_used[i] = 1'b0;
         live_count   = 0;
         pick_state   = 32'd1;
         outcome_q.delete();
         mismatches   = 0;
         ops_seen     = 0;
         picks_hit    = 0;
         peak_members = 0;
      end else begin
         // A result leaving at this edge always belongs to an earlier request.
         if (rsp_tvalid && rsp_tready) begin
            if (outcome_q.size() == 0) begin
               report_mismatch("result transfer with nothing pending", 32'(rsp_tdata),
                               32'd0);
            end else begin
               due = outcome_q.pop_front();
               if (rsp_tdata[0] !== due.ok)
                  report_mismatch("ok", 32'(rsp_tdata[0]), 32'(due.ok));
               if (rsp_tdata[12:1] !== due.picked)
                  report_mismatch("picked", 32'(rsp_tdata[12:1]), 32'(due.picked));
               if (rsp_tdata[23:13] !== due.members)
                  report_mismatch("member_count", 32'(rsp_tdata[23:13]), 32'(due.members));
            end
         end
         if (csr_valid && csr_ready) begin
            pick_state = (csr_data != 32'd0) ? csr_data : 32'd1;
         end
         if (req_tvalid && req_tready) begin
            fresh = apply_set_op(req_tuser, req_tdata[rst_pkg::VALUE_W-1:0]);
            outcome_q.push_back(fresh);
            ops_seen++;
            if (req_tuser == rst_pkg::ACT_PICK && fresh.ok)
               picks_hit++;
            if (live_count > peak_members)
               peak_members = live_count;
         end
      end
      outstanding = outcome_q.size();
   end

endmodule

// File: sim/randomized_set_table_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Randomized set table testbench
// Drives directed and random insert, remove and pick requests through four
// flow-control mixes and several seeds, fills the store to capacity once, and
// reports the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module randomized_set_table_test;

   localparam logic [rst_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;
   localparam int QUIET_LIMIT   = 20000;
   localparam int SETTLE_CYCLES = 60;
   localparam int FILL_INSERTS  = 1030;
   localparam int KEY_SPACE     = 4096;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;    // [11:0] value, [15:12] zero
   logic [1:0]  req_tuser;    // [1:0] action
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;    // [0] ok, [12:1] picked, [23:13] member_count
   logic        csr_valid;
   logic        csr_ready;
   logic [31:0] csr_data;     // random_seed

   int mismatches;
   int outstanding;
   int ops_seen;
   int picks_hit;
   int peak_members;

   int idle_pct;
   int stall_pct;
   int quiet_cycles;
   logic [rst_pkg::VALUE_W-1:0] shuffled [KEY_SPACE];

   randomized_set_table DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   randomized_set_table_checker set_check (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_data     (csr_data),
      .mismatches   (mismatches),
      .outstanding  (outstanding),
      .ops_seen     (ops_seen),
      .picks_hit    (picks_hit),
      .peak_members (peak_members)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_tready = ($urandom_range(99, 0) >= stall_pct);
   end

   // Ends the run if no transfer of any kind happens for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Valid stays high after the transfer so back-to-back items need no dip.
   task automatic send_op(input logic [rst_pkg::ACTION_W-1:0] act,
                          input logic [rst_pkg::VALUE_W-1:0] val);
      @(negedge clock);
      while ($urandom_range(99, 0) < idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = act;
      req_tdata  = {4'b0, val};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic write_seed(input logic [31:0] seed);
      wait_drained();
      @(negedge clock);
      csr_valid = 1'b1;
      csr_data  = seed;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Mostly values from a narrow window around zero so removes find members.
   task automatic random_op(input int span);
      int roll;
      logic [rst_pkg::ACTION_W-1:0] act;
      logic [rst_pkg::VALUE_W-1:0] val;
      roll = $urandom_range(99, 0);
      if (roll < 40)
         act = rst_pkg::ACT_INSERT;
      else if (roll < 70)
         act = rst_pkg::ACT_REMOVE;
      else if (roll < 95)
         act = rst_pkg::ACT_PICK;
      else
         act = ACT_UNUSED;
      if ($urandom_range(3, 0) != 0)
         val = rst_pkg::VALUE_W'(int'($urandom_range(2 * span - 1, 0)) - span);
      else
         val = rst_pkg::VALUE_W'($urandom);
      send_op(act, val);
   endtask

   initial begin
      int j;
      int roll;
      logic [rst_pkg::VALUE_W-1:0] swap;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = rst_pkg::ACT_INSERT;
      rsp_tready = 1'b0;
      csr_valid  = 1'b0;
      csr_data   = '0;
      idle_pct   = 0;
      stall_pct  = 0;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // Directed: empty-set rejects, extremes, duplicates, swap-on-remove
      // from the middle, first and last slots, and the unused action code.
      send_op(rst_pkg::ACT_PICK,   12'h000);
      send_op(rst_pkg::ACT_REMOVE, 12'h800);
      send_op(ACT_UNUSED,          12'h5A5);
      send_op(rst_pkg::ACT_INSERT, 12'h800);
      send_op(rst_pkg::ACT_INSERT, 12'h7FF);
      send_op(rst_pkg::ACT_INSERT, 12'h000);
      send_op(rst_pkg::ACT_INSERT, 12'hFFF);
      send_op(rst_pkg::ACT_INSERT, 12'h7FF);
      send_op(rst_pkg::ACT_PICK,   12'hFFF);
      send_op(rst_pkg::ACT_PICK,   12'h000);
      send_op(rst_pkg::ACT_PICK,   12'h7FF);
      send_op(rst_pkg::ACT_REMOVE, 12'h000);
      send_op(rst_pkg::ACT_REMOVE, 12'h000);
      send_op(ACT_UNUSED,          12'hFFF);
      send_op(rst_pkg::ACT_REMOVE, 12'hFFF);
      send_op(rst_pkg::ACT_INSERT, 12'h555);
      send_op(rst_pkg::ACT_INSERT, 12'hAAA);
      send_op(rst_pkg::ACT_PICK,   12'h000);
      send_op(rst_pkg::ACT_REMOVE, 12'h800);
      send_op(rst_pkg::ACT_REMOVE, 12'h7FF);
      send_op(rst_pkg::ACT_PICK,   12'h000);
      send_op(rst_pkg::ACT_REMOVE, 12'h555);
      send_op(rst_pkg::ACT_REMOVE, 12'hAAA);
      send_op(rst_pkg::ACT_PICK,   12'h000);

      write_seed(32'hFFFF_FFFF);
      repeat (16) random_op(16);

      // A zero seed must fall back to one. The fill pass then inserts distinct
      // values in random order until the store is full and runs into the
      // full-store reject, with picks and duplicates mixed in, while the
      // flow-control mix changes twice along the way.
      write_seed(32'h0000_0000);
      idle_pct  = 51;
      stall_pct = 0;
      for (int i = 0; i < KEY_SPACE; i++) shuffled[i] = rst_pkg::VALUE_W'(i);
      for (int i = KEY_SPACE - 1; i > 0; i--) begin
         j = $urandom_range(i, 0);
         swap = shuffled[i];
         shuffled[i] = shuffled[j];
         shuffled[j] = swap;
      end
      for (int i = 0; i < FILL_INSERTS; i++) begin
         if (i == FILL_INSERTS / 3) begin
            idle_pct  = 0;
            stall_pct = 51;
         end else if (i == 2 * FILL_INSERTS / 3) begin
            idle_pct  = 35;
            stall_pct = 35;
         end
         if (i % 128 == 127)
            send_op(rst_pkg::ACT_PICK, rst_pkg::VALUE_W'($urandom));
         if (i % 128 == 63)
            send_op(rst_pkg::ACT_INSERT, shuffled[$urandom_range(i - 1, 0)]);
         send_op(rst_pkg::ACT_INSERT, shuffled[i]);
      end

      write_seed(32'h0000_0001);
      for (int i = 0; i < 24; i++) begin
         if (i % 8 == 7)
            wait_drained();
         roll = $urandom_range(99, 0);
         if (roll < 45)
            send_op(rst_pkg::ACT_REMOVE, shuffled[$urandom_range(FILL_INSERTS - 1, 0)]);
         else if (roll < 65)
            send_op(rst_pkg::ACT_INSERT, shuffled[$urandom_range(FILL_INSERTS + 40, 0)]);
         else if (roll < 95)
            send_op(rst_pkg::ACT_PICK, rst_pkg::VALUE_W'($urandom));
         else
            send_op(ACT_UNUSED, rst_pkg::VALUE_W'($urandom));
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("Ran %0d set operations, %0d of them successful random picks, over",
               ops_seen, picks_hit);
      $display("several seeds and four flow-control mixes; membership peaked at %0d.",
               peak_members);
      if (mismatches == 0 && outstanding == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
